/* design/assert_macros.svh */
// Assertion macros used by the checker file of the framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("framer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");

`endif

/* design/krf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key report framer package
// Frame layout constants, command codes, register codes and shared types.
// ----------------------------------------------------------------------------
package krf_pkg;

	localparam int FRAME_LEN    = 32;
	localparam int BYTE_IDX_W   = 5;
	localparam int PAYLOAD_POS  = 3;
	localparam int PAYLOAD_LEN  = 6;
	localparam int IDLE_POS     = 9;
	localparam int BITMAP_POS   = 10;
	localparam int BITMAP_LEN   = 20;
	localparam int TAIL_W       = 3;

	localparam logic [7:0] SOF_BYTE    = 8'hAA;
	localparam logic [7:0] LEN_BYTE    = 8'(FRAME_LEN - 3);
	localparam logic [7:0] TYPE_BYTE   = 8'h02;
	localparam logic [7:0] CSUM_SEED   = 8'h55;
	localparam logic [7:0] PHANTOM_KEY = 8'h01;

	typedef enum logic [1:0] {
		CMD_SIX_KEY  = 2'd0,
		CMD_BITMAP   = 2'd1,
		CMD_TAIL     = 2'd2,
		CMD_BASELINE = 2'd3
	} cmd_t;

	typedef enum logic {
		CFG_FORCE_ACTIVE = 1'b0,
		CFG_IDLE_OFF     = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic force_active;
		logic idle_off;
	} cfg_t;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

endpackage

/* design/krf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer channel interfaces
// Report command channel, frame byte channel and register write channel.
// ----------------------------------------------------------------------------
interface krf_report_if import krf_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [47:0] key_report;
	logic [7:0]  modifiers;
	logic [63:0] bitmap_low;
	logic [63:0] bitmap_mid;
	logic [31:0] bitmap_high;

	modport source (output valid, cmd, key_report, modifiers, bitmap_low, bitmap_mid,
		bitmap_high, input ready);
	modport sink (input valid, cmd, key_report, modifiers, bitmap_low, bitmap_mid,
		bitmap_high, output ready);
endinterface

interface krf_frame_if import krf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [7:0]            frame_byte;
	logic [BYTE_IDX_W-1:0] byte_index;
	logic                  last_byte;

	modport source (output valid, frame_byte, byte_index, last_byte, input ready);
	modport sink (input valid, frame_byte, byte_index, last_byte, output ready);
endinterface

interface krf_cfg_if ();
	logic valid;
	logic ready;
	logic addr;
	logic data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

/* design/krf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer byte cell
// One byte of the frame line: loads in parallel, then passes its byte on.
// ----------------------------------------------------------------------------
module krf_cell (
	input  logic       clk,
	input  logic       load,
	input  logic       shift,
	input  logic [7:0] load_byte,
	input  logic [7:0] next_byte,
	output logic [7:0] cell_byte
);

	logic [7:0] byte_q;

	// A load takes priority over a shift from the neighbor.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= load_byte;
		end else if (shift) begin
			byte_q <= next_byte;
		end
	end

	assign cell_byte = byte_q;

endmodule

/* design/krf_builder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer command decoder
// Builds the frame body for a command and keeps the tail and baseline state.
// ----------------------------------------------------------------------------
module krf_builder import krf_pkg::*; #(
	parameter int TAIL_FRAMES = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  cfg_t        cfg,
	input  logic [1:0]  cmd,
	input  logic [47:0] key_report,
	input  logic [7:0]  modifiers,
	input  logic [63:0] bitmap_low,
	input  logic [63:0] bitmap_mid,
	input  logic [31:0] bitmap_high,
	output logic        has_frame,
	output frame_t      frame
);

	logic              prev_active_q;
	logic [TAIL_W-1:0] tail_q;
	logic              baseline_q;

	cmd_t                               cmd_c;
	logic [PAYLOAD_LEN-1:0][7:0]        six_p;
	logic [BITMAP_LEN-1:0][7:0]         bitmap;
	logic                               six_active;
	logic                               bitmap_active;
	logic                               active;

	assign cmd_c  = cmd_t'(cmd);
	assign bitmap = {bitmap_high, bitmap_mid, bitmap_low};

	// Six-key payload: report bytes, or the tail pattern, zeroed by a pending baseline.
	always_comb begin
		six_p = key_report;
		if (cmd_c == CMD_TAIL) begin
			six_p = '0;
			if (!tail_q[0]) begin
				six_p[1] = PHANTOM_KEY;
			end
		end
		if (baseline_q) begin
			six_p = '0;
		end
	end

	assign six_active    = |six_p;
	assign bitmap_active = (|modifiers) || (|bitmap);
	assign active        = (cmd_c == CMD_BITMAP) ? bitmap_active : six_active;

	// Frame body; the checksum byte is produced at the output.
	always_comb begin
		frame     = '0;
		frame[0]  = SOF_BYTE;
		frame[1]  = LEN_BYTE;
		frame[2]  = TYPE_BYTE;
		has_frame = 1'b0;
		case (cmd_c)
			CMD_SIX_KEY, CMD_TAIL: begin
				for (int i = 0; i < PAYLOAD_LEN; i++) begin
					frame[PAYLOAD_POS + i] = six_p[i];
				end
				has_frame = (cmd_c == CMD_SIX_KEY) || (tail_q != '0);
			end
			CMD_BITMAP: begin
				frame[PAYLOAD_POS] = modifiers;
				for (int i = 0; i < BITMAP_LEN; i++) begin
					frame[BITMAP_POS + i] = bitmap[i];
				end
				has_frame = 1'b1;
			end
			default: begin
				has_frame = 1'b0;
			end
		endcase
		frame[IDLE_POS] = {7'd0, !(cfg.force_active || cfg.idle_off || active)};
	end

	// Tail, activity and baseline bookkeeping for each accepted command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_active_q <= 1'b0;
			tail_q        <= '0;
			baseline_q    <= 1'b0;
		end else if (accept) begin
			case (cmd_c)
				CMD_SIX_KEY, CMD_BITMAP: begin
					if (cmd_c == CMD_SIX_KEY) begin
						baseline_q <= 1'b0;
					end
					if (active) begin
						tail_q <= '0;
					end else if (prev_active_q) begin
						tail_q <= TAIL_W'(TAIL_FRAMES);
					end
					prev_active_q <= active;
				end
				CMD_TAIL: begin
					if (tail_q != '0) begin
						tail_q        <= tail_q - 1'b1;
						baseline_q    <= 1'b0;
						prev_active_q <= active;
					end
				end
				CMD_BASELINE: begin
					baseline_q    <= 1'b1;
					prev_active_q <= 1'b0;
					tail_q        <= '0;
				end
				default: begin
					baseline_q <= baseline_q;
				end
			endcase
		end
	end

endmodule

/* design/key_report_framer_with_release_tail_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key report framer with release tail
// Turns keyboard report commands into 32-byte radio frames, one byte a beat.
// ----------------------------------------------------------------------------
// A command is decoded in the cycle it is accepted and its frame parked in a
// one-deep holding register. The frame then loads into a line of 32 byte
// cells and shifts out one byte per cycle while the output is ready.
// The next command is accepted while the current frame is still shifting
// out. Commands that produce no frame (an empty tail tick, a baseline
// restart) do not enter the holding register. The checksum byte is formed
// from a running sum as the earlier bytes leave. Output stalls simply hold
// the line.
module key_report_framer_with_release_tail_top import krf_pkg::*; #(
	parameter int TAIL_FRAMES = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	krf_report_if.sink    report,
	krf_frame_if.source   frame,
	krf_cfg_if.sink       cfg
);

	cfg_t                  cfg_q;
	logic                  hold_valid_q;
	frame_t                hold_frame_q;
	logic                  busy_q;
	logic [BYTE_IDX_W-1:0] idx_q;
	logic [7:0]            sum_q;

	logic                  in_fire;
	logic                  out_fire;
	logic                  last_fire;
	logic                  load;
	logic                  has_frame;
	frame_t                built_frame;
	logic [FRAME_LEN-1:0][7:0] cell_bytes;

	assign out_fire  = frame.valid && frame.ready;
	assign last_fire = out_fire && (idx_q == BYTE_IDX_W'(FRAME_LEN - 1));
	assign load      = hold_valid_q && (!busy_q || last_fire);
	assign in_fire   = report.valid && report.ready;

	assign report.ready = !hold_valid_q || load;
	assign cfg.ready    = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.addr))
				CFG_FORCE_ACTIVE: cfg_q.force_active <= cfg.data;
				CFG_IDLE_OFF:     cfg_q.idle_off     <= cfg.data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	krf_builder #(
		.TAIL_FRAMES(TAIL_FRAMES)
	) u_builder (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_fire),
		.cfg         (cfg_q),
		.cmd         (report.cmd),
		.key_report  (report.key_report),
		.modifiers   (report.modifiers),
		.bitmap_low  (report.bitmap_low),
		.bitmap_mid  (report.bitmap_mid),
		.bitmap_high (report.bitmap_high),
		.has_frame   (has_frame),
		.frame       (built_frame)
	);

	// Holding register between the decoder and the cell line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (in_fire && has_frame) begin
			hold_valid_q <= 1'b1;
		end else if (load) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && has_frame) begin
			hold_frame_q <= built_frame;
		end
	end

	// Line of byte cells; cell 0 faces the output.
	for (genvar g = 0; g < FRAME_LEN; g++) begin : g_cell
		logic [7:0] next_byte;
		if (g == FRAME_LEN - 1) begin : g_end
			assign next_byte = 8'h00;
		end else begin : g_mid
			assign next_byte = cell_bytes[g + 1];
		end
		krf_cell u_cell (
			.clk       (clk),
			.load      (load),
			.shift     (out_fire),
			.load_byte (hold_frame_q[g]),
			.next_byte (next_byte),
			.cell_byte (cell_bytes[g])
		);
	end

	// Output position, running byte sum and frame occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			sum_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			sum_q  <= '0;
		end else if (out_fire) begin
			busy_q <= !last_fire;
			idx_q  <= idx_q + 1'b1;
			sum_q  <= sum_q + cell_bytes[0];
		end
	end

	assign frame.valid      = busy_q;
	assign frame.byte_index = idx_q;
	assign frame.last_byte  = (idx_q == BYTE_IDX_W'(FRAME_LEN - 1));
	assign frame.frame_byte = frame.last_byte ? (CSUM_SEED - sum_q) : cell_bytes[0];

endmodule

/* design/krf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer port checker
// Watches the frame channel for ordering and framing slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module krf_checker import krf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [7:0]            frame_byte,
	input logic [BYTE_IDX_W-1:0] byte_index,
	input logic                  last_byte
);

	logic                  stall;
	logic                  mid_fire;
	logic                  idx_last;
	logic [BYTE_IDX_W-1:0] idx_inc;

	// Handshake views of the frame channel.
	assign stall    = out_valid && !out_ready;
	assign mid_fire = out_valid && out_ready && !last_byte;
	assign idx_last = (byte_index == BYTE_IDX_W'(FRAME_LEN - 1));
	assign idx_inc  = byte_index + 1'b1;

	// A stalled byte holds.
	`KRF_ASSERT_NEXT(a_hold, clk, arst_n, stall, out_valid && $stable(frame_byte))

	// The end marker sits on the checksum position only.
	`KRF_ASSERT_NOW(a_last, clk, arst_n, out_valid, last_byte == idx_last)

	// Within a frame the bytes follow one another without a gap in position.
	`KRF_ASSERT_NEXT(a_seq, clk, arst_n, mid_fire, out_valid && byte_index == $past(idx_inc))

	// Every frame opens with the start byte.
	`KRF_ASSERT_NOW(a_sof, clk, arst_n, out_valid && (byte_index == '0), frame_byte == SOF_BYTE)

endmodule

bind key_report_framer_with_release_tail_top krf_checker u_krf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (frame.valid),
	.out_ready  (frame.ready),
	.frame_byte (frame.frame_byte),
	.byte_index (frame.byte_index),
	.last_byte  (frame.last_byte)
);
